>>> design/pfc_pkg.sv
// Shared types and constants for the prime factor count block.
`default_nettype none

package pfc_pkg;

    localparam int COUNT_W = 5;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;
    localparam int OUT_TDATA_W = 8;

    typedef struct packed {
        logic load;         // capture magnitude, reset divisor and count
        logic div_start;    // begin m / d
        logic take_factor;  // m <= m / d, count++
        logic next_div;     // step to next candidate divisor
        logic finish;       // fold in the leftover cofactor, write result
    } pfc_cmd_t;

    typedef struct packed {
        logic div_done;
        logic d_gt_q;       // divisor above quotient: past the square root
        logic rem_zero;
    } pfc_status_t;

endpackage

`default_nettype wire

>>> design/pfc_ctrl.sv
// Controller state machine for the prime factor count block.
`default_nettype none

module pfc_ctrl
    import pfc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire pfc_status_t status,
    output pfc_cmd_t         cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_START = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;
    localparam logic [1:0] ST_EVAL  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                if (status.div_done) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (status.d_gt_q) begin
                    // result waits here until the output register is free
                    if (out_free) begin
                        cmd.finish     = 1'b1;
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end else if (status.rem_zero) begin
                    cmd.take_factor = 1'b1;
                    state_next      = ST_START;
                end else begin
                    cmd.next_div = 1'b1;
                    state_next   = ST_START;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

>>> design/pfc_datapath.sv
// Datapath: cofactor, divisor, count and a bit-serial restoring divider.
`default_nettype none

module pfc_datapath
    import pfc_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic [VALUE_WIDTH-1:0] value,
    input  wire pfc_cmd_t               cmd,
    output pfc_status_t                 status,
    output logic [COUNT_W-1:0]          factor_count
);

    localparam int W     = VALUE_WIDTH;
    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]       m_reg, m_next;
    logic [W-1:0]       d_reg, d_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] result_reg, result_next;
    logic [W:0]         rem_reg, rem_next;
    logic [W-1:0]       quo_reg, quo_next;
    logic [CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;

    logic [W-1:0]       magnitude;
    logic [W:0]         trial;
    logic [W:0]         diff;
    logic               fits;
    logic [COUNT_W-1:0] count_inc;

    // most negative value maps to 2^(W-1), which fits unsigned
    assign magnitude = value[W-1] ? (~value + W'(1)) : value;

    assign trial = {rem_reg[W-1:0], quo_reg[W-1]};
    assign diff  = trial - {1'b0, d_reg};
    assign fits  = (trial >= {1'b0, d_reg});

    assign count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + COUNT_W'(1);

    assign status.div_done = (bit_cnt_reg == '0);
    assign status.d_gt_q   = (d_reg > quo_reg);
    assign status.rem_zero = (rem_reg == '0);
    assign factor_count    = result_reg;

    always_comb begin
        m_next       = m_reg;
        d_next       = d_reg;
        count_next   = count_reg;
        result_next  = result_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        bit_cnt_next = bit_cnt_reg;

        if (cmd.load) begin
            m_next     = magnitude;
            d_next     = W'(2);
            count_next = '0;
        end
        if (cmd.div_start) begin
            rem_next     = '0;
            quo_next     = m_reg;
            bit_cnt_next = CNT_W'(W);
        end else if (bit_cnt_reg != '0) begin
            rem_next     = fits ? diff : trial;
            quo_next     = {quo_reg[W-2:0], fits};
            bit_cnt_next = bit_cnt_reg - CNT_W'(1);
        end
        if (cmd.take_factor) begin
            m_next     = quo_reg;
            count_next = count_inc;
        end
        // after 2 only odd candidates can be prime
        if (cmd.next_div) begin
            d_next = (d_reg == W'(2)) ? W'(3) : d_reg + W'(2);
        end
        if (cmd.finish) begin
            result_next = (m_reg > W'(1)) ? count_inc : count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_cnt_reg <= '0;
        end else begin
            bit_cnt_reg <= bit_cnt_next;
        end
        m_reg      <= m_next;
        d_reg      <= d_next;
        count_reg  <= count_next;
        result_reg <= result_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
    end

endmodule

`default_nettype wire

>>> design/prime_factor_count.sv
// Top level: counts prime factors of a signed integer's magnitude.
//
// Input channel s_*: one item carries a two's complement value in the low
// VALUE_WIDTH bits of s_tdata. Output channel m_*: one item per input,
// factor_count (prime factors of |value| with multiplicity, saturating at
// 31) in the low 5 bits of m_tdata. Zero and plus or minus one give 0.
// Factors are found by trial division with divisors 2, 3, 5, 7, ...; each
// candidate runs one restoring division, one quotient bit per cycle.
// One item is in work at a time; s_tready is high only while idle.
// The result sits in an output register, so a new item is accepted while
// the previous result still waits; if the receiver stalls, the next item
// holds its finished result until the register frees.
// Synchronous active-low reset returns to idle with no pending result.
`default_nettype none

module prime_factor_count
    import pfc_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [((VALUE_WIDTH+7)/8)*8-1:0] s_tdata,  // [VALUE_WIDTH-1:0] value
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata    // [4:0] factor_count
);

    pfc_cmd_t           cmd;
    pfc_status_t        status;
    logic [COUNT_W-1:0] factor_count;

    pfc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pfc_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .value        (s_tdata[VALUE_WIDTH-1:0]),
        .cmd          (cmd),
        .status       (status),
        .factor_count (factor_count)
    );

    assign m_tdata = {{(OUT_TDATA_W-COUNT_W){1'b0}}, factor_count};

endmodule

`default_nettype wire
